// ===== design/swbd_pkg.sv =====
// Shared types and constants for the sync word bit deframer.
`timescale 1ns / 1ps
`default_nettype none
package swbd_pkg;

	localparam int SYNC_BITS_MAX_DEF = 64;
	localparam int RUN_MAX_DEF       = 15;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int SYNC_LEN_W = 7;
	localparam int IDX_W      = 10;
	localparam int FLEN_W     = 11;
	localparam int RUN_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int BITPOS_W   = 3;
	localparam int KIND_W     = 2;
	localparam int RESCNT_W   = 2;
	localparam logic [RESCNT_W-1:0] MAX_RESULTS = 2'd3;

	localparam logic [CFG_DATA_W-1:0] SYNC_WORD_RST   = 64'h086D53884469481F;
	localparam logic [SYNC_LEN_W-1:0] SYNC_LEN_RST    = 7'd64;
	localparam logic [IDX_W-1:0]      FRAME_START_RST = 10'd8;
	localparam logic [FLEN_W-1:0]     FRAME_LEN_RST   = 11'd320;
	localparam logic [IDX_W-1:0]      GAP_RESET_RST   = 10'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_WORD   = 3'd0,
		REG_SYNC_LENGTH = 3'd1,
		REG_FRAME_START = 3'd2,
		REG_FRAME_LEN   = 3'd3,
		REG_GAP_RESET   = 3'd4
	} reg_index_t;

	typedef enum logic [KIND_W-1:0] {
		EV_SYNC  = 2'd0,
		EV_DATA  = 2'd1,
		EV_ABORT = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              frame_end;
		logic              last_of_run;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic bit_step;
		logic gap_step;
		logic flush;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic pend_valid;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== design/swbd_if.sv =====
// Input run channel and output result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface swbd_in_if;
	logic                      valid;
	logic                      ready;
	logic                      bit_value;
	logic [swbd_pkg::RUN_W-1:0] run_length;

	modport source (output valid, output bit_value, output run_length, input ready);
	modport sink (input valid, input bit_value, input run_length, output ready);
endinterface

interface swbd_out_if;
	logic                       valid;
	logic                       ready;
	logic [swbd_pkg::KIND_W-1:0] event_kind;
	logic [swbd_pkg::BYTE_W-1:0] data_byte;
	logic [swbd_pkg::IDX_W-1:0]  byte_index;
	logic                       frame_end;
	logic                       last_of_run;

	modport source (output valid, output event_kind, output data_byte, output byte_index,
		output frame_end, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input data_byte, input byte_index,
		input frame_end, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== design/sync_word_bit_deframer.sv =====
// Top level of the sync word bit deframer.
//
// Input channel in_ch carries bit runs: bit_value repeated run_length times,
// run_length zero meaning a signal gap. Output channel out_ch carries events:
// sync found, data byte (LSB first, with its frame index) or frame aborted.
// Each run gives zero to three results; last_of_run marks the final one.
// Configuration registers are written through write_enable, reg_index and
// write_data; the user must do so only while the block is idle, which the
// block itself does not enforce. A run is accepted, then one bit step runs
// per bit (run_length, at most RUN_MAX), or a single gap step for a gap, then
// a flush step; no new run is taken until the flush is done.
// The newest result waits in a pending register until the next one or the
// end of the run; the one before it moves to the output register. When the
// receiver stalls with the output register full, the bit loop holds.
// Reset clears history, frame state and buffers and loads the default
// configuration; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module sync_word_bit_deframer #(
	parameter int SYNC_BITS_MAX = swbd_pkg::SYNC_BITS_MAX_DEF,
	parameter int RUN_MAX       = swbd_pkg::RUN_MAX_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	swbd_in_if.sink                              in_ch,
	swbd_out_if.source                           out_ch,
	input  wire logic                            write_enable,
	input  wire logic [swbd_pkg::CFG_IDX_W-1:0]  reg_index,
	input  wire logic [swbd_pkg::CFG_DATA_W-1:0] write_data
);
	import swbd_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	result_t   res;
	logic      res_valid;

	swbd_ctrl #(
		.RUN_MAX (RUN_MAX)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_run_length (in_ch.run_length),
		.in_ready      (in_ch.ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	swbd_datapath #(
		.SYNC_BITS_MAX (SYNC_BITS_MAX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_bit       (in_ch.bit_value),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.out_ready    (out_ch.ready),
		.out_valid    (res_valid),
		.out_res      (res)
	);

	assign out_ch.valid       = res_valid;
	assign out_ch.event_kind  = res.event_kind;
	assign out_ch.data_byte   = res.data_byte;
	assign out_ch.byte_index  = res.byte_index;
	assign out_ch.frame_end   = res.frame_end;
	assign out_ch.last_of_run = res.last_of_run;

	// Busy after taking a run
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input ready right after a transaction");

	// No result left pending while waiting for a new run
	a_no_pend_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !stat.pend_valid)
		else $error("pending result left behind at idle");

	// Sync and abort events carry no byte and never end a frame
	a_event_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.event_kind != EV_DATA) |->
			(out_ch.data_byte == '0) && !out_ch.frame_end)
		else $error("non-data event with byte payload");

endmodule
`default_nettype wire

// ===== design/swbd_ctrl.sv =====
// Controller: takes runs, steps one bit per cycle while out_free, then flushes.
`timescale 1ns / 1ps
`default_nettype none
module swbd_ctrl #(
	parameter int RUN_MAX = swbd_pkg::RUN_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [swbd_pkg::RUN_W-1:0] in_run_length,
	output logic                            in_ready,
	input  wire swbd_pkg::dp_stat_t         stat,
	output swbd_pkg::ctrl_cmd_t             cmd
);
	import swbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_GAP,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	logic [RUN_W-1:0] rem_q;
	logic [RUN_W-1:0] run_eff;
	logic             accept;

	// Clamp the run to the longest processed length
	always_comb begin
		run_eff = in_run_length;
		if (int'(in_run_length) > RUN_MAX) begin
			run_eff = RUN_W'(RUN_MAX);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Issue datapath commands
	always_comb begin
		cmd = '0;
		cmd.load = accept;
		case (state_q)
			ST_RUN:   cmd.bit_step = stat.out_free;
			ST_GAP:   cmd.gap_step = stat.out_free;
			ST_FLUSH: cmd.flush    = stat.out_free && stat.pend_valid;
			default:  cmd = cmd;
		endcase
	end

	// Hold state and the remaining bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rem_q   <= run_eff;
						state_q <= (run_eff == '0) ? ST_GAP : ST_RUN;
					end
				end
				ST_RUN: begin
					if (stat.out_free) begin
						rem_q <= rem_q - RUN_W'(1);
						if (rem_q == RUN_W'(1)) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_GAP: begin
					if (stat.out_free) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!stat.pend_valid || stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/swbd_datapath.sv =====
// Datapath: config registers, bit history, sync compare, byte packing, result buffers.
`timescale 1ns / 1ps
`default_nettype none
module swbd_datapath #(
	parameter int SYNC_BITS_MAX = swbd_pkg::SYNC_BITS_MAX_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire swbd_pkg::ctrl_cmd_t             cmd,
	output swbd_pkg::dp_stat_t                   stat,
	input  wire logic                            in_bit,
	input  wire logic                            write_enable,
	input  wire logic [swbd_pkg::CFG_IDX_W-1:0]  reg_index,
	input  wire logic [swbd_pkg::CFG_DATA_W-1:0] write_data,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output swbd_pkg::result_t                    out_res
);
	import swbd_pkg::*;

	localparam int FILL_W = $clog2(SYNC_BITS_MAX + 1);

	// Configuration registers
	logic [CFG_DATA_W-1:0] sync_word_q;
	logic [SYNC_LEN_W-1:0] sync_len_q;
	logic [IDX_W-1:0]      frame_start_q;
	logic [FLEN_W-1:0]     frame_size_q;
	logic [IDX_W-1:0]      gap_reset_q;

	// Deframer state
	logic [SYNC_BITS_MAX-1:0] hist_q;
	logic [FILL_W-1:0]        fill_q;
	logic                     in_frame_q;
	logic [BITPOS_W-1:0]      pos_q;
	logic [BYTE_W-1:0]        shift_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     bit_q;
	logic [RESCNT_W-1:0]      res_cnt_q;
	logic                     pend_valid_q;
	result_t                  pend_q;
	logic                     out_valid_q;
	result_t                  out_q;

	// Next-state values
	logic [SYNC_BITS_MAX-1:0] hist_n;
	logic [FILL_W-1:0]        fill_n;
	logic                     in_frame_n;
	logic [BITPOS_W-1:0]      pos_n;
	logic [BYTE_W-1:0]        shift_n;
	logic [IDX_W-1:0]         idx_n;
	logic [FLEN_W-1:0]        next_idx;
	logic [SYNC_LEN_W-1:0]    len_c;
	logic [SYNC_BITS_MAX-1:0] bit_ok;
	logic                     match;
	logic                     new_valid;
	result_t                  new_res;
	logic                     out_free;
	logic                     res_take;
	result_t                  flush_res;

	assign out_free = !out_valid_q || out_ready;
	assign stat.out_free   = out_free;
	assign stat.pend_valid = pend_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Clamp sync length and compare the newest bits with the sync word
	always_comb begin
		len_c = sync_len_q;
		if (sync_len_q == '0) begin
			len_c = SYNC_LEN_W'(1);
		end else if (int'(sync_len_q) > SYNC_BITS_MAX) begin
			len_c = SYNC_LEN_W'(SYNC_BITS_MAX);
		end
		hist_n = {hist_q[SYNC_BITS_MAX-2:0], bit_q};
		fill_n = (int'(fill_q) == SYNC_BITS_MAX) ? fill_q : fill_q + FILL_W'(1);
		for (int i = 0; i < SYNC_BITS_MAX; i++) begin
			bit_ok[i] = (i >= int'(len_c)) || (hist_n[i] == sync_word_q[i]);
		end
		match = (int'(fill_n) >= int'(len_c)) && (&bit_ok);
	end

	// Work out one bit step or one gap step
	always_comb begin
		in_frame_n = in_frame_q;
		pos_n      = pos_q;
		shift_n    = shift_q;
		idx_n      = idx_q;
		next_idx   = {1'b0, idx_q} + FLEN_W'(1);
		new_valid  = 1'b0;
		new_res    = '0;
		if (cmd.bit_step) begin
			if (!in_frame_q) begin
				if (match) begin
					in_frame_n = 1'b1;
					pos_n      = '0;
					shift_n    = '0;
					idx_n      = frame_start_q;
					new_valid  = 1'b1;
					new_res.event_kind = EV_SYNC;
					new_res.byte_index = frame_start_q;
				end
			end else begin
				shift_n = shift_q | (BYTE_W'(bit_q) << pos_q);
				pos_n   = pos_q + BITPOS_W'(1);
				if (pos_q == '1) begin
					new_valid          = 1'b1;
					new_res.event_kind = EV_DATA;
					new_res.data_byte  = shift_n;
					new_res.byte_index = idx_q;
					new_res.frame_end  = (next_idx == frame_size_q);
					shift_n = '0;
					idx_n   = next_idx[IDX_W-1:0];
					if (next_idx == frame_size_q) begin
						in_frame_n = 1'b0;
						idx_n      = frame_start_q;
					end
				end
			end
		end else if (cmd.gap_step) begin
			if (in_frame_q && (idx_q > gap_reset_q)) begin
				new_valid          = 1'b1;
				new_res.event_kind = EV_ABORT;
				new_res.byte_index = idx_q;
				in_frame_n = 1'b0;
				pos_n      = '0;
				shift_n    = '0;
				idx_n      = frame_start_q;
			end
		end
	end

	// Take a new result unless the per-run limit is reached
	assign res_take = !cmd.load && new_valid && (res_cnt_q != MAX_RESULTS);

	// Mark the pending result as the final one of the run
	always_comb begin
		flush_res             = pend_q;
		flush_res.last_of_run = 1'b1;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q   <= SYNC_WORD_RST;
			sync_len_q    <= SYNC_LEN_RST;
			frame_start_q <= FRAME_START_RST;
			frame_size_q  <= FRAME_LEN_RST;
			gap_reset_q   <= GAP_RESET_RST;
		end else if (write_enable) begin
			case (reg_index)
				REG_SYNC_WORD:   sync_word_q   <= write_data;
				REG_SYNC_LENGTH: sync_len_q    <= write_data[SYNC_LEN_W-1:0];
				REG_FRAME_START: frame_start_q <= write_data[IDX_W-1:0];
				REG_FRAME_LEN:   frame_size_q  <= write_data[FLEN_W-1:0];
				REG_GAP_RESET:   gap_reset_q   <= write_data[IDX_W-1:0];
				default:         sync_len_q    <= sync_len_q;
			endcase
		end
	end

	// Advance deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q     <= '0;
			fill_q     <= '0;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			shift_q    <= '0;
			idx_q      <= FRAME_START_RST;
		end else begin
			if (cmd.bit_step) begin
				hist_q <= hist_n;
				fill_q <= fill_n;
			end
			if (cmd.bit_step || cmd.gap_step) begin
				in_frame_q <= in_frame_n;
				pos_q      <= pos_n;
				shift_q    <= shift_n;
				idx_q      <= idx_n;
			end
		end
	end

	// Latch the run bit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bit_q <= in_bit;
		end
	end

	// Hold one pending result so the final one can be marked; drop beyond the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				res_cnt_q <= '0;
			end else if (res_take) begin
				res_cnt_q    <= res_cnt_q + RESCNT_W'(1);
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			// Load the output register, or free it once the transaction is taken
			if ((res_take && pend_valid_q) || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload registers
	always_ff @(posedge clk) begin
		if (res_take) begin
			pend_q <= new_res;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end else if (cmd.flush) begin
			out_q <= flush_res;
		end
	end

endmodule
`default_nettype wire

// ===== verif/sync_word_bit_deframer_tb.sv =====
// Self-checking testbench for the sync word bit deframer: run stimulus, event prediction, checks.
`timescale 1ns / 1ps
module sync_word_bit_deframer_tb;
	import swbd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int RUN_TARGET     = 380;

	// Predict deframer events and match them against the output channel
	class deframer_scoreboard;
		logic [CFG_DATA_W-1:0] sync_word;
		logic [SYNC_LEN_W-1:0] sync_len;
		logic [IDX_W-1:0]      frame_start;
		logic [FLEN_W-1:0]     frame_size;
		logic [IDX_W-1:0]      gap_limit;
		logic [63:0]           history;
		int unsigned           fill;
		bit                    in_frame;
		logic [BITPOS_W-1:0]   bit_pos;
		logic [BYTE_W-1:0]     shift;
		logic [IDX_W-1:0]      byte_idx;
		result_t               run_q[$];
		result_t               expected_q[$];
		int unsigned           errors;

		function new();
			sync_word   = SYNC_WORD_RST;
			sync_len    = SYNC_LEN_RST;
			frame_start = FRAME_START_RST;
			frame_size  = FRAME_LEN_RST;
			gap_limit   = GAP_RESET_RST;
			history     = '0;
			fill        = 0;
			in_frame    = 1'b0;
			bit_pos     = '0;
			shift       = '0;
			byte_idx    = FRAME_START_RST;
			errors      = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_SYNC_WORD:   sync_word = value;
				REG_SYNC_LENGTH: sync_len = value[SYNC_LEN_W-1:0];
				REG_FRAME_START: frame_start = value[IDX_W-1:0];
				REG_FRAME_LEN:   frame_size = value[FLEN_W-1:0];
				REG_GAP_RESET:   gap_limit = value[IDX_W-1:0];
				default: ;
			endcase
		endfunction

		function bit sync_hit();
			int unsigned len;
			logic [63:0] mask;
			len = sync_len;
			if (len < 1) len = 1;
			if (len > SYNC_BITS_MAX_DEF) len = SYNC_BITS_MAX_DEF;
			if (fill < len) return 1'b0;
			mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
			return ((history ^ sync_word) & mask) == 64'd0;
		endfunction

		// Drop events past the per-run limit; state still advances
		function void add_event(event_kind_t kind, logic [BYTE_W-1:0] data,
				logic [IDX_W-1:0] idx, logic fend);
			result_t r;
			r.event_kind  = kind;
			r.data_byte   = data;
			r.byte_index  = idx;
			r.frame_end   = fend;
			r.last_of_run = 1'b0;
			if (run_q.size() < MAX_RESULTS) run_q.push_back(r);
		endfunction

		function void note_run(logic bit_v, logic [RUN_W-1:0] run_len);
			int unsigned n;
			int unsigned i;
			logic [FLEN_W-1:0] next_idx;
			logic fend;
			run_q.delete();
			n = run_len;
			if (n > RUN_MAX_DEF) n = RUN_MAX_DEF;
			if (n == 0) begin
				// A gap aborts the frame only past the gap threshold
				if (in_frame && byte_idx > gap_limit) begin
					add_event(EV_ABORT, '0, byte_idx, 1'b0);
					in_frame = 1'b0;
					bit_pos  = '0;
					shift    = '0;
					byte_idx = frame_start;
				end
			end else begin
				for (i = 0; i < n; i++) begin
					history = {history[62:0], bit_v};
					if (fill < SYNC_BITS_MAX_DEF) fill++;
					if (!in_frame) begin
						if (sync_hit()) begin
							in_frame = 1'b1;
							bit_pos  = '0;
							shift    = '0;
							byte_idx = frame_start;
							add_event(EV_SYNC, '0, frame_start, 1'b0);
						end
					end else begin
						// Pack LSB first, emit on the eighth bit
						shift[bit_pos] = bit_v;
						bit_pos = bit_pos + 1'b1;
						if (bit_pos == 0) begin
							next_idx = {1'b0, byte_idx} + 1'b1;
							fend = (next_idx == frame_size);
							add_event(EV_DATA, shift, byte_idx, fend);
							shift    = '0;
							byte_idx = next_idx[IDX_W-1:0];
							if (fend) begin
								in_frame = 1'b0;
								byte_idx = frame_start;
							end
						end
					end
				end
			end
			if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
			foreach (run_q[k]) expected_q.push_back(run_q[k]);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.event_kind !== want.event_kind) begin
				errors++;
				$display("%0t: event_kind expected %0d actual %0d", $time,
					want.event_kind, got.event_kind);
			end
			if (got.data_byte !== want.data_byte) begin
				errors++;
				$display("%0t: data_byte expected %02h actual %02h", $time,
					want.data_byte, got.data_byte);
			end
			if (got.byte_index !== want.byte_index) begin
				errors++;
				$display("%0t: byte_index expected %0d actual %0d", $time,
					want.byte_index, got.byte_index);
			end
			if (got.frame_end !== want.frame_end) begin
				errors++;
				$display("%0t: frame_end expected %0b actual %0b", $time,
					want.frame_end, got.frame_end);
			end
			if (got.last_of_run !== want.last_of_run) begin
				errors++;
				$display("%0t: last_of_run expected %0b actual %0b", $time,
					want.last_of_run, got.last_of_run);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  write_enable;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] write_data;

	swbd_in_if  in_ch();
	swbd_out_if out_ch();

	sync_word_bit_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	deframer_scoreboard sb;
	bit                 steady;
	int unsigned        runs_sent;
	bit                 stream_q[$];
	logic [63:0]        cur_word;
	logic [6:0]         cur_len;
	logic [9:0]         cur_start;
	logic [10:0]        cur_flen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Record accepted runs and check accepted events
	always @(posedge clk) begin : monitor
		result_t seen;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				seen.event_kind  = out_ch.event_kind;
				seen.data_byte   = out_ch.data_byte;
				seen.byte_index  = out_ch.byte_index;
				seen.frame_end   = out_ch.frame_end;
				seen.last_of_run = out_ch.last_of_run;
				sb.check_result(seen);
			end
			if (in_ch.valid && in_ch.ready)
				sb.note_run(in_ch.bit_value, in_ch.run_length);
		end
	end

	// Stall the output side in random bursts
	initial begin : receiver
		int unsigned hold;
		out_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 13) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || write_enable)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic pause_sender(int unsigned cycles);
		@(negedge clk);
		in_ch.valid      <= 1'b0;
		in_ch.bit_value  <= 1'($urandom_range(0, 1));
		in_ch.run_length <= RUN_W'($urandom_range(0, 15));
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send_run(logic bit_v, logic [RUN_W-1:0] len);
		if (runs_sent + 50 >= RUN_TARGET) steady = 1'b1;
		if (!steady && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 13));
		@(negedge clk);
		in_ch.valid      <= 1'b1;
		in_ch.bit_value  <= bit_v;
		in_ch.run_length <= len;
		do @(posedge clk); while (!in_ch.ready);
		runs_sent++;
	endtask

	task automatic hold_sender();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Wait out all pending events, then the block's own run latency
	task automatic wait_drained();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	// Fill the unused upper bits of a narrow register write with junk
	function automatic logic [63:0] with_junk(logic [63:0] v, int unsigned w);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		return (junk << w) | v;
	endfunction

	task automatic program_regs(logic [63:0] word, logic [6:0] len, logic [9:0] start,
			logic [10:0] flen, logic [9:0] gap_after);
		hold_sender();
		wait_drained();
		load_reg(REG_SYNC_WORD, word);
		load_reg(REG_SYNC_LENGTH, with_junk(64'(len), SYNC_LEN_W));
		load_reg(REG_FRAME_START, with_junk(64'(start), IDX_W));
		load_reg(REG_FRAME_LEN, with_junk(64'(flen), FLEN_W));
		load_reg(REG_GAP_RESET, with_junk(64'(gap_after), IDX_W));
		@(negedge clk);
		write_enable <= 1'b0;
		cur_word  = word;
		cur_len   = len;
		cur_start = start;
		cur_flen  = flen;
	endtask

	function automatic int unsigned sync_span();
		if (cur_len == 0) return 1;
		if (cur_len > SYNC_BITS_MAX_DEF) return SYNC_BITS_MAX_DEF;
		return cur_len;
	endfunction

	function automatic int unsigned frame_bytes();
		int unsigned n;
		if (cur_flen > cur_start) n = cur_flen - cur_start;
		else if (cur_flen != 0 && cur_flen <= 1024) n = 1024 - cur_start + cur_flen;
		else n = 4;
		return (n > 40) ? 40 : n;
	endfunction

	// Sync word goes out first-received bit first; data bytes LSB first
	function automatic void queue_word(logic [63:0] w, int unsigned n);
		int i;
		for (i = int'(n) - 1; i >= 0; i--) stream_q.push_back(w[i]);
	endfunction

	function automatic void queue_byte(logic [7:0] b);
		int i;
		for (i = 0; i < 8; i++) stream_q.push_back(b[i]);
	endfunction

	// Cut the bit stream into runs of equal bits with random caps
	task automatic send_stream();
		bit b;
		int unsigned n;
		int unsigned cap;
		while (stream_q.size() > 0) begin
			b = stream_q.pop_front();
			n = 1;
			cap = $urandom_range(0, 1) ? 15 : $urandom_range(1, 15);
			while (n < cap && stream_q.size() > 0 && stream_q[0] == b) begin
				void'(stream_q.pop_front());
				n++;
			end
			send_run(b, n[RUN_W-1:0]);
		end
	endtask

	// Mostly whole frames with random data; some noise and cut-short frames
	task automatic random_phase(int unsigned goal);
		int unsigned nbytes;
		bit cut;
		while (runs_sent < goal) begin
			if ($urandom_range(0, 9) < 2) begin
				repeat ($urandom_range(1, 4))
					send_run(1'($urandom_range(0, 1)), RUN_W'($urandom_range(0, 15)));
			end else begin
				repeat ($urandom_range(0, 6)) stream_q.push_back(1'($urandom_range(0, 1)));
				queue_word(cur_word, sync_span());
				nbytes = frame_bytes();
				cut = ($urandom_range(0, 5) == 0);
				if (cut) nbytes = $urandom_range(0, nbytes);
				repeat (nbytes) queue_byte(8'($urandom_range(0, 255)));
				if (cut)
					repeat ($urandom_range(0, 7)) stream_q.push_back(1'($urandom_range(0, 1)));
				send_stream();
				if (cut || $urandom_range(0, 3) == 0) send_run(1'($urandom_range(0, 1)), 4'd0);
			end
		end
	endtask

	initial begin : stimulus
		logic [63:0] word;
		logic [6:0]  len;
		logic [9:0]  start;
		logic [10:0] flen;
		logic [9:0]  gap_after;
		sb = new();
		steady           = 1'b0;
		runs_sent        = 0;
		arst_n           = 1'b0;
		write_enable     = 1'b0;
		reg_index        = '0;
		write_data       = '0;
		in_ch.valid      = 1'b0;
		in_ch.bit_value  = 1'b0;
		in_ch.run_length = '0;
		cur_word  = SYNC_WORD_RST;
		cur_len   = SYNC_LEN_RST;
		cur_start = FRAME_START_RST;
		cur_flen  = FRAME_LEN_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: gap while hunting, longest run of zeros
		send_run(1'b0, 4'd0);
		send_run(1'b0, 4'd15);

		// One-bit sync, two-byte frames: end by length, gap below and above threshold
		program_regs(64'h1, 7'd1, 10'd0, 11'd2, 10'd0);
		send_run(1'b1, 4'd1);
		send_run(1'b1, 4'd15);
		send_run(1'b0, 4'd1);
		send_run(1'b1, 4'd3);
		send_run(1'b0, 4'd0);
		send_run(1'b0, 4'd6);
		send_run(1'b1, 4'd0);

		// Zero sync length, frame length zero, index wrap from the top start
		program_regs('1, 7'd0, 10'd1023, 11'd0, 10'd1023);
		send_run(1'b1, 4'd15);
		send_run(1'b0, 4'd2);
		send_run(1'b1, 4'd0);

		// Oversized sync length against an all-zero word, largest frame length
		program_regs(64'h0, 7'd127, 10'd5, 11'd2047, 10'd0);
		send_run(1'b1, 4'd0);
		repeat (5) send_run(1'b0, 4'd15);
		send_run(1'b0, 4'd0);

		// One-byte frames: three events from one run
		program_regs(64'h1, 7'd1, 10'd0, 11'd1, 10'd1023);
		send_run(1'b1, 4'd15);
		send_run(1'b1, 4'd15);

		// Random settings, each followed by framed traffic
		while (runs_sent < RUN_TARGET) begin
			word = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: begin
					word = SYNC_WORD_RST;
					len  = 7'd64;
				end
				1: len = ($urandom_range(0, 1)) ? 7'd0 : 7'($urandom_range(65, 127));
				2: len = 7'd64;
				default: len = 7'($urandom_range(1, 24));
			endcase
			case ($urandom_range(0, 5))
				0: begin
					start = 10'($urandom_range(1015, 1023));
					flen  = 11'($urandom_range(1, 4));
				end
				1: begin
					start = 10'd0;
					flen  = 11'd1;
				end
				default: begin
					start = 10'($urandom_range(0, 12));
					flen  = 11'(start) + 11'($urandom_range(1, 5));
				end
			endcase
			case ($urandom_range(0, 5))
				0: gap_after = 10'd0;
				1: gap_after = 10'd1023;
				default: gap_after = 10'($urandom_range(0, 15));
			endcase
			program_regs(word, len, start, flen, gap_after);
			send_run(1'($urandom_range(0, 1)), 4'd0);
			random_phase(runs_sent + $urandom_range(35, 55));
		end

		hold_sender();
		wait_drained();
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
